[rtl/u8sd_pkg.sv]
// ----------------------------------------------------------------------------
// u8sd_pkg: shared types and helpers for the UTF-8 stream decoder
// Result word layout, status codes, markers and decode helper functions.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam logic [31:0] MARK_INCOMPLETE = 32'h0000_fffe;
  localparam logic [31:0] MARK_BAD        = 32'h0000_ffff;

  localparam logic [1:0] ST_VALID      = 2'd0;
  localparam logic [1:0] ST_BAD        = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;

  // Output queue depth (words held between the decoder and the output port)
  localparam int QDEPTH = 3;

  typedef struct packed {
    logic [31:0] code_point;
    logic [1:0]  status;
    logic        last;
  } res_t;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [2:0]  rem;      // continuation bytes still expected, 0 = idle
    logic [2:0]  seq_len;  // length of the sequence in progress
    logic [31:0] partial;  // gathered payload bits
  } dec_state_t;

  // Sequence length from the lead byte; 0 marks a stray continuation byte
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] n;
    unique casez (b)
      8'b0???????: n = 3'd1;
      8'b10??????: n = 3'd0;
      8'b110?????: n = 3'd2;
      8'b1110????: n = 3'd3;
      8'b11110???: n = 3'd4;
      8'b111110??: n = 3'd5;
      8'b1111110?: n = 3'd6;
      default:     n = 3'd7;
    endcase
    return n;
  endfunction

  // Shortest encoding length of a 32-bit value (7 payload bits, 11 for two bytes, then 5 more per byte)
  function automatic logic [2:0] minimal_length(input logic [31:0] v);
    logic [2:0] n;
    if (v[31:7] == '0)       n = 3'd1;
    else if (v[31:11] == '0) n = 3'd2;
    else if (v[31:16] == '0) n = 3'd3;
    else if (v[31:21] == '0) n = 3'd4;
    else if (v[31:26] == '0) n = 3'd5;
    else if (!v[31])         n = 3'd6;
    else                     n = 3'd7;
    return n;
  endfunction

endpackage

[rtl/u8sd_decode.sv]
// ----------------------------------------------------------------------------
// u8sd_decode: per-byte decode step
// Combinational next state and up to two result words for one input byte.
// ----------------------------------------------------------------------------
module u8sd_decode (
  input  logic [7:0]           data_byte,
  input  u8sd_pkg::dec_state_t st,
  output u8sd_pkg::dec_state_t st_next,
  output logic [1:0]           nres,
  output u8sd_pkg::res_t       res0,
  output u8sd_pkg::res_t       res1
);
  import u8sd_pkg::*;

  logic [2:0]  lead_n;
  logic [7:0]  lead_payload;
  logic        is_cont;
  logic        start_has_res;
  res_t        start_res;
  dec_state_t  start_st;
  logic [31:0] acc;

  always_comb begin
    lead_n       = lead_length(data_byte);
    lead_payload = data_byte & (8'hff >> lead_n);
    is_cont      = (data_byte[7:6] == 2'b10);
    acc          = {st.partial[25:0], data_byte[5:0]};

    // Result of treating this byte as the start of a new sequence
    start_has_res        = (lead_n <= 3'd1);
    start_res.last       = 1'b1;
    if (lead_n == 3'd0) begin
      start_res.code_point = MARK_BAD;
      start_res.status     = ST_BAD;
    end else begin
      start_res.code_point = {24'd0, data_byte};
      start_res.status     = ST_VALID;
    end
    start_st = st;
    start_st.rem = 3'd0;
    if (!start_has_res) begin
      start_st.rem     = lead_n - 3'd1;
      start_st.seq_len = lead_n;
      start_st.partial = {24'd0, lead_payload};
    end

    st_next = st;
    nres    = 2'd0;
    res0    = start_res;
    res1    = start_res;

    if (st.rem != 3'd0) begin
      if (is_cont) begin
        st_next.partial = acc;
        st_next.rem     = st.rem - 3'd1;
        if (st.rem == 3'd1) begin
          nres      = 2'd1;
          res0.last = 1'b1;
          if (minimal_length(acc) == st.seq_len) begin
            res0.code_point = acc;
            res0.status     = ST_VALID;
          end else begin
            res0.code_point = MARK_BAD;
            res0.status     = ST_BAD;
          end
        end
      end else begin
        // broken sequence: report it, then restart on this byte
        st_next         = start_st;
        res0.code_point = MARK_INCOMPLETE;
        res0.status     = ST_INCOMPLETE;
        res0.last       = !start_has_res;
        nres            = start_has_res ? 2'd2 : 2'd1;
      end
    end else begin
      st_next = start_st;
      nres    = start_has_res ? 2'd1 : 2'd0;
    end
  end

endmodule

[rtl/utf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder: byte-serial extended UTF-8 decoder
// One byte per word in, 32-bit code points with status out.
// ----------------------------------------------------------------------------
// Accepts one byte per clock while in_stall is low and decodes extended
// UTF-8 (1 to 7 byte sequences) into 32-bit code points. Each input byte is
// registered, decoded combinationally against the running sequence state,
// and its results (none, one or two) are pushed into a three-word output
// queue whose head drives the output port. A result thus passes the input
// register and then the output queue register before it reaches the port.
// Sustained rate is one byte per cycle while the output drains one
// word per cycle; a byte that breaks a pending sequence and also completes on
// its own (an incomplete marker followed by a second word) adds one word to
// the queue, so the input stalls while the queue holds two or more words.
// status: 0 valid code point, 1 bad or overlong (0xffff),
// 2 incomplete sequence (0xfffe). last marks the final word caused by a byte.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  // result output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] code_point,
  output logic [1:0]  status,
  output logic        last
);
  import u8sd_pkg::*;

  // input register
  logic       byte_vld;
  logic [7:0] byte_q;

  // sequence state
  dec_state_t st;
  dec_state_t st_next;

  // decode results for the registered byte
  logic [1:0] nres;
  res_t       res0;
  res_t       res1;

  // output queue, slot 0 is the head
  res_t       q      [QDEPTH];
  res_t       q_next [QDEPTH];
  logic [1:0] cnt;
  logic [1:0] cnt_pop;
  logic [1:0] cnt_next;
  logic       pop;
  logic       proc_go;

  // a byte is decoded only when the queue has room for two words
  assign proc_go  = byte_vld && (cnt <= 2'd1);
  assign in_stall = byte_vld && !proc_go;

  assign out_valid  = (cnt != 2'd0);
  assign pop        = out_valid && !out_stall;
  assign code_point = q[0].code_point;
  assign status     = q[0].status;
  assign last       = q[0].last;

  u8sd_decode u_decode (
    .data_byte (byte_q),
    .st        (st),
    .st_next   (st_next),
    .nres      (nres),
    .res0      (res0),
    .res1      (res1)
  );

  // queue update: shift out the head, then append new words behind the rest
  always_comb begin
    cnt_pop = cnt - {1'b0, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_next[i] = q[i + 1];
      end
    end
    cnt_next = cnt_pop;
    if (proc_go) begin
      for (int i = 0; i < QDEPTH; i++) begin
        if ((nres != 2'd0) && (cnt_pop == 2'(i)))
          q_next[i] = res0;
        if ((nres == 2'd2) && (cnt_pop + 2'd1 == 2'(i)))
          q_next[i] = res1;
      end
      cnt_next = cnt_pop + nres;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
      cnt      <= 2'd0;
      st       <= '0;
    end else begin
      if (!in_stall) byte_vld <= in_valid;
      cnt <= cnt_next;
      if (proc_go) st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) byte_q <= data_byte;
    q <= q_next;
  end

`ifndef SYNTHESIS
  // a byte is only decoded with room for both of its possible words
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    proc_go |-> (cnt_pop <= 2'd1))
    else $error("output queue overflow");

  // incomplete status always carries the incomplete marker
  a_incomplete_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_INCOMPLETE)) |-> (code_point == MARK_INCOMPLETE))
    else $error("incomplete status without incomplete marker");

  // bad status always carries the bad marker
  a_bad_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_BAD)) |-> (code_point == MARK_BAD))
    else $error("bad status without bad marker");

  // pending count stays below the longest sequence length
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    st.rem <= 3'd6)
    else $error("pending byte count out of range");
`endif

endmodule
